>>> rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared widths, operation codes and defaults for the burst byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned CntW  = 13;  // byte counts and capacity
  localparam int unsigned OpW   = 3;
  localparam int unsigned DataW = 8;
  localparam int unsigned PctW  = 7;   // fill percent, 0 to 100
  localparam int unsigned StepW = $clog2(PctW);
  // Holds the largest fill count times the percent scale.
  localparam int unsigned DivW  = 20;

  localparam int unsigned PctScale   = 100;
  localparam int unsigned DefDepth   = 4096;
  localparam int unsigned DefMaxRead = 64;

  typedef logic [CntW-1:0] cnt_t;

  localparam logic [OpW-1:0] OP_WRITE  = OpW'(0);
  localparam logic [OpW-1:0] OP_READ   = OpW'(1);
  localparam logic [OpW-1:0] OP_PEEK   = OpW'(2);
  localparam logic [OpW-1:0] OP_CLEAR  = OpW'(3);
  localparam logic [OpW-1:0] OP_STATUS = OpW'(4);

endpackage

>>> rtl/brb_in_if.sv
// ----------------------------------------------------------------------------
// brb_in_if
// Request channel of the burst byte ring buffer: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface brb_in_if;
  import brb_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  cnt_t             length;
  logic [DataW-1:0] data_in;
  logic             burst_start;

  modport source (output valid, operation, length, data_in, burst_start, input ready);
  modport sink   (input valid, operation, length, data_in, burst_start, output ready);
endinterface

>>> rtl/brb_out_if.sv
// ----------------------------------------------------------------------------
// brb_out_if
// Result channel of the burst byte ring buffer: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface brb_out_if;
  import brb_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_out;
  logic             byte_valid;
  logic             last;
  logic             accepted;
  cnt_t             transfer_count;
  cnt_t             fill_count;
  cnt_t             free_count;
  logic [PctW-1:0]  fill_percent;

  modport source (output valid, data_out, byte_valid, last, accepted, transfer_count,
                  fill_count, free_count, fill_percent, input ready);
  modport sink   (input valid, data_out, byte_valid, last, accepted, transfer_count,
                  fill_count, free_count, fill_percent, output ready);
endinterface

>>> rtl/byte_ring_buffer_burst.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst
// Circular byte FIFO with whole-burst write admission, read, peek, clear and
// status. Each request is taken in the idle state, then the load state starts
// the shared divider and the calc state computes the fill percent one quotient
// bit at a time; results follow from an output register at one per cycle
// while the result channel is ready, the bytes of a read or peek streaming
// from the single read port of the store. The store needs no clearing pass
// after reset.
// ----------------------------------------------------------------------------
module byte_ring_buffer_burst #(
  parameter int unsigned DEPTH    = brb_pkg::DefDepth,
  parameter int unsigned MAX_READ = brb_pkg::DefMaxRead
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  brb_pkg::cnt_t     cfg_data_i,
  brb_in_if.sink            req_i,
  brb_out_if.source         rsp_o
);
  import brb_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned SumW = ((PtrW > CntW) ? PtrW : CntW) + 1;
  localparam int unsigned RdW  = $clog2(MAX_READ + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       state_q, state_d;
  cnt_t             cap_q, cap_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  cnt_t             held_q, held_d;
  cnt_t             burst_left_q, burst_left_d;
  logic             burst_ok_q, burst_ok_d;
  cnt_t             grant_q, grant_d;
  logic [PtrW-1:0]  cursor_q, cursor_d;
  logic [RdW-1:0]   cnt_q, cnt_d;
  cnt_t             xfer_q, xfer_d;
  logic             acc_q, acc_d;
  logic             byte_mode_q, byte_mode_d;

  logic [DataW-1:0] mem [DEPTH];
  logic [DataW-1:0] rd_data_q;

  logic             req_acc;
  logic             rsp_acc;
  logic             wr_en;
  cnt_t             space;
  cnt_t             bl_sel;
  logic             ok_sel;
  cnt_t             grant_sel;
  cnt_t             rn;
  logic [SumW-1:0]  ptr_sum;
  logic [SumW-1:0]  ptr_wrap;
  cnt_t             cap_sat;
  logic             div_done;
  logic [DivW-1:0]  pct_num;
  logic [PctW-1:0]  pct;

  function automatic logic [PtrW-1:0] adv(input logic [PtrW-1:0] p, input cnt_t cap);
    logic [SumW-1:0] n;
    n = SumW'(p) + SumW'(1);
    return (n >= SumW'(cap)) ? '0 : n[PtrW-1:0];
  endfunction

  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_acc     = rsp_o.valid && rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // Admission check for a burst that starts with this request, or the stored result of the running burst.
  assign space     = cap_q - held_q;
  assign bl_sel    = req_i.burst_start ? req_i.length : burst_left_q;
  assign ok_sel    = req_i.burst_start ? ((req_i.length != '0) && (req_i.length <= space))
                                       : burst_ok_q;
  assign grant_sel = req_i.burst_start ? (ok_sel ? req_i.length : '0) : grant_q;

  assign cap_sat = (32'(cfg_data_i) > DEPTH) ? CntW'(DEPTH) : cfg_data_i;

  always_comb begin
    rn = req_i.length;
    if (rn > CntW'(MAX_READ)) begin
      rn = CntW'(MAX_READ);
    end
    if (rn > held_q) begin
      rn = held_q;
    end
    ptr_sum  = SumW'(rd_ptr_q) + SumW'(rn);
    ptr_wrap = (ptr_sum >= SumW'(cap_q)) ? (ptr_sum - SumW'(cap_q)) : ptr_sum;
  end

  always_comb begin
    state_d      = state_q;
    cap_d        = cap_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    held_d       = held_q;
    burst_left_d = burst_left_q;
    burst_ok_d   = burst_ok_q;
    grant_d      = grant_q;
    cursor_d     = cursor_q;
    cnt_d        = cnt_q;
    xfer_d       = xfer_q;
    acc_d        = acc_q;
    byte_mode_d  = byte_mode_q;
    wr_en        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          state_d     = ST_LOAD;
          cnt_d       = RdW'(1);
          xfer_d      = '0;
          acc_d       = 1'b0;
          byte_mode_d = 1'b0;
          unique case (req_i.operation) inside
            OP_WRITE: begin
              burst_left_d = bl_sel;
              burst_ok_d   = ok_sel;
              grant_d      = grant_sel;
              if (bl_sel != '0) begin
                burst_left_d = bl_sel - CntW'(1);
                if (ok_sel) begin
                  if (held_q < cap_q) begin
                    wr_en    = 1'b1;
                    wr_ptr_d = adv(wr_ptr_q, cap_q);
                    held_d   = held_q + CntW'(1);
                    acc_d    = 1'b1;
                  end else begin
                    // Store filled up under a running burst: give it up.
                    burst_left_d = '0;
                    burst_ok_d   = 1'b0;
                    grant_d      = '0;
                  end
                end
              end
              xfer_d = grant_d;
            end
            OP_READ, OP_PEEK: begin
              if (rn != '0) begin
                byte_mode_d = 1'b1;
                cnt_d       = rn[RdW-1:0];
                xfer_d      = rn;
                cursor_d    = rd_ptr_q;
                if (req_i.operation == OP_READ) begin
                  held_d   = held_q - rn;
                  rd_ptr_d = ptr_wrap[PtrW-1:0];
                end
              end
            end
            OP_CLEAR: begin
              rd_ptr_d     = '0;
              wr_ptr_d     = '0;
              held_d       = '0;
              burst_left_d = '0;
              burst_ok_d   = 1'b0;
              grant_d      = '0;
            end
            default: begin
              // Status and unused codes leave the state alone.
            end
          endcase
        end
      end
      ST_LOAD: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (rsp_acc) begin
          if (cnt_q == RdW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d    = cnt_q - RdW'(1);
            cursor_d = adv(cursor_q, cap_q);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      cap_d        = cap_sat;
      rd_ptr_d     = '0;
      wr_ptr_d     = '0;
      held_d       = '0;
      burst_left_d = '0;
      burst_ok_d   = 1'b0;
      grant_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cap_q        <= CntW'(DEPTH);
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      held_q       <= '0;
      burst_left_q <= '0;
      burst_ok_q   <= 1'b0;
      grant_q      <= '0;
    end else begin
      state_q      <= state_d;
      cap_q        <= cap_d;
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      held_q       <= held_d;
      burst_left_q <= burst_left_d;
      burst_ok_q   <= burst_ok_d;
      grant_q      <= grant_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q    <= cursor_d;
    cnt_q       <= cnt_d;
    xfer_q      <= xfer_d;
    acc_q       <= acc_d;
    byte_mode_q <= byte_mode_d;
  end

  // The read address follows the next cursor so a new byte is ready every cycle while the result channel is ready.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_ptr_q] <= req_i.data_in;
    end
    rd_data_q <= mem[cursor_d];
  end

  assign pct_num = DivW'(held_q) * DivW'(PctScale);

  brb_pct_div u_pct_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_LOAD),
    .dividend_i (pct_num),
    .divisor_i  (cap_q),
    .done_o     (div_done),
    .quot_o     (pct)
  );

  assign rsp_o.valid          = (state_q == ST_OUT);
  assign rsp_o.data_out       = byte_mode_q ? rd_data_q : '0;
  assign rsp_o.byte_valid     = byte_mode_q;
  assign rsp_o.last           = (cnt_q == RdW'(1));
  assign rsp_o.accepted       = acc_q;
  assign rsp_o.transfer_count = xfer_q;
  assign rsp_o.fill_count     = held_q;
  assign rsp_o.free_count     = cap_q - held_q;
  assign rsp_o.fill_percent   = pct;

endmodule

>>> rtl/brb_pct_div.sv
// ----------------------------------------------------------------------------
// brb_pct_div
// Restoring divider that yields the fill percent one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brb_pct_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [brb_pkg::DivW-1:0]   dividend_i,
  input  brb_pkg::cnt_t              divisor_i,
  output logic                       done_o,
  output logic [brb_pkg::PctW-1:0]   quot_o
);
  import brb_pkg::*;

  logic              busy_q;
  logic [StepW-1:0]  step_q;
  logic [DivW-1:0]   rem_q;
  logic [PctW-1:0]   quot_q;
  cnt_t              div_q;
  logic              zero_q;
  logic [DivW-1:0]   trial;
  logic              fits;

  // The quotient never exceeds 100, so seven shifted trial subtractions suffice.
  assign trial  = DivW'(div_q) << step_q;
  assign fits   = rem_q >= trial;
  assign done_o = busy_q && (step_q == '0);
  assign quot_o = zero_q ? '0 : quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepW'(PctW - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      quot_q <= '0;
      div_q  <= divisor_i;
      zero_q <= (divisor_i == '0);
    end else if (busy_q && fits) begin
      rem_q          <= rem_q - trial;
      quot_q[step_q] <= 1'b1;
    end
  end

endmodule
